// ===== design/assert_macros.svh =====
// Assertion macros shared by the checker modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/tlnef_pkg.sv =====
// ----------------------------------------------------------------------------
// tlnef_pkg: shared types and constants of the line number and escape filter
// Holds the configuration bundle, the per-word expansion descriptor and the
// ASCII codes used by the front and back parts.
// ----------------------------------------------------------------------------
package tlnef_pkg;

    // Configuration register indexes
    localparam logic [2:0] CFG_NUMBER_NONBLANK  = 3'd0;
    localparam logic [2:0] CFG_NUMBER_ALL       = 3'd1;
    localparam logic [2:0] CFG_SQUEEZE_BLANK    = 3'd2;
    localparam logic [2:0] CFG_MARK_LINE_END    = 3'd3;
    localparam logic [2:0] CFG_SHOW_TABS        = 3'd4;
    localparam logic [2:0] CFG_SHOW_NONPRINTING = 3'd5;

    // Character codes
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_I      = 8'h49;
    localparam logic [7:0] CH_M      = 8'h4D;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_QUEST  = 8'h3F;
    localparam logic [6:0] CH_DEL    = 7'h7F;
    localparam logic [6:0] CTL_MAX   = 7'd31;
    localparam logic [6:0] CARET_OFS = 7'd64;

    // Longest expansion of one text byte ("M-^X")
    localparam int CHR_MAX = 4;

    // Blank run counter saturates here
    localparam logic [1:0] BLANK_SAT = 2'd2;

    typedef struct packed {
        logic number_nonblank;
        logic number_all;
        logic squeeze_blank;
        logic mark_line_end;
        logic show_tabs;
        logic show_nonprinting;
    } t_cfg;

    // Character part of one queued word; bytes[0] goes out first
    typedef struct packed {
        logic                      num_en;
        logic [1:0]                last_idx;
        logic [CHR_MAX-1:0][7:0]   bytes;
    } t_chr;

endpackage

// ===== design/tlnef_front.sv =====
// ----------------------------------------------------------------------------
// tlnef_front: line tracking and classification
// Tracks line start, blank runs and the BCD line count, decides whether a
// word is dropped, renders the line number and works out the byte expansion.
// ----------------------------------------------------------------------------
module tlnef_front #(
    parameter int NUMBER_DIGITS = 6
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  tlnef_pkg::t_cfg            i_cfg,
    input  logic                       i_accept,
    input  logic [7:0]                 i_byte,
    input  logic                       i_new_file,
    output logic                       o_push,
    output tlnef_pkg::t_chr            o_chr,
    output logic [NUMBER_DIGITS*8-1:0] o_num
);

    localparam int CW = NUMBER_DIGITS * 4;

    logic          r_at_start, n_at_start;
    logic [1:0]    r_blank_run, n_blank_run;
    logic [CW-1:0] r_count, n_count;

    logic          line_start;
    logic [1:0]    run_in;
    logic          is_nl;
    logic          drop;
    logic          num_en;
    logic          full;
    logic          carry;
    logic [3:0]    dig;
    logic          seen;
    logic          hi;
    logic [6:0]    low;
    logic          ctl;
    logic [7:0]    fin;

    // Line and blank run state
    always_comb begin
        line_start  = r_at_start | i_new_file;
        run_in      = i_new_file ? 2'd0 : r_blank_run;
        is_nl       = (i_byte == tlnef_pkg::CH_NL);
        n_blank_run = run_in;
        drop        = 1'b0;
        num_en      = 1'b0;
        if (line_start) begin
            if (is_nl) begin
                n_blank_run = (run_in < tlnef_pkg::BLANK_SAT) ? run_in + 2'd1 : run_in;
            end else begin
                n_blank_run = 2'd0;
            end
            drop = i_cfg.squeeze_blank && (n_blank_run > 2'd1);
            if (!drop) begin
                num_en = i_cfg.number_nonblank ? !is_nl : i_cfg.number_all;
            end
        end
        n_at_start = drop ? 1'b1 : is_nl;
    end

    // Advance the BCD count, holding at all nines
    always_comb begin
        full    = 1'b1;
        for (int j = 0; j < NUMBER_DIGITS; j++) begin
            if (r_count[j*4 +: 4] != 4'd9) begin
                full = 1'b0;
            end
        end
        n_count = r_count;
        carry   = 1'b1;
        if (num_en && !full) begin
            for (int j = 0; j < NUMBER_DIGITS; j++) begin
                if (carry) begin
                    if (r_count[j*4 +: 4] >= 4'd9) begin
                        n_count[j*4 +: 4] = 4'd0;
                    end else begin
                        n_count[j*4 +: 4] = r_count[j*4 +: 4] + 4'd1;
                        carry             = 1'b0;
                    end
                end
            end
        end
    end

    // Render the number, leading zeros as spaces, leftmost digit at byte 0
    always_comb begin
        o_num = '0;
        seen  = 1'b0;
        dig   = '0;
        for (int j = NUMBER_DIGITS - 1; j >= 0; j--) begin
            dig = (r_count[j*4 +: 4] > 4'd9) ? 4'd9 : r_count[j*4 +: 4];
            if (dig != 4'd0 || j == 0) begin
                seen = 1'b1;
            end
            o_num[(NUMBER_DIGITS-1-j)*8 +: 8] =
                seen ? (tlnef_pkg::CH_ZERO + {4'd0, dig}) : tlnef_pkg::CH_SPACE;
        end
    end

    // Expand the byte itself
    always_comb begin
        hi  = i_byte[7];
        low = i_byte[6:0];
        ctl = (low <= tlnef_pkg::CTL_MAX) || (low == tlnef_pkg::CH_DEL);
        if (low <= tlnef_pkg::CTL_MAX) begin
            fin = {1'b0, low + tlnef_pkg::CARET_OFS};
        end else if (low == tlnef_pkg::CH_DEL) begin
            fin = tlnef_pkg::CH_QUEST;
        end else begin
            fin = {1'b0, low};
        end
        o_chr.num_en   = num_en;
        o_chr.bytes    = '0;
        o_chr.last_idx = 2'd0;
        if (i_cfg.mark_line_end && is_nl) begin
            o_chr.bytes[0] = tlnef_pkg::CH_DOLLAR;
            o_chr.bytes[1] = tlnef_pkg::CH_NL;
            o_chr.last_idx = 2'd1;
        end else if (i_cfg.show_tabs && i_byte == tlnef_pkg::CH_TAB) begin
            o_chr.bytes[0] = tlnef_pkg::CH_CARET;
            o_chr.bytes[1] = tlnef_pkg::CH_I;
            o_chr.last_idx = 2'd1;
        end else if (i_cfg.show_nonprinting && !is_nl && i_byte != tlnef_pkg::CH_TAB) begin
            case ({hi, ctl})
                2'b11: begin
                    o_chr.bytes    = {fin, tlnef_pkg::CH_CARET, tlnef_pkg::CH_DASH,
                                      tlnef_pkg::CH_M};
                    o_chr.last_idx = 2'd3;
                end
                2'b10: begin
                    o_chr.bytes[0] = tlnef_pkg::CH_M;
                    o_chr.bytes[1] = tlnef_pkg::CH_DASH;
                    o_chr.bytes[2] = fin;
                    o_chr.last_idx = 2'd2;
                end
                2'b01: begin
                    o_chr.bytes[0] = tlnef_pkg::CH_CARET;
                    o_chr.bytes[1] = fin;
                    o_chr.last_idx = 2'd1;
                end
                default: begin
                    o_chr.bytes[0] = fin;
                end
            endcase
        end else begin
            o_chr.bytes[0] = i_byte;
        end
    end

    assign o_push = i_accept && !drop;

    // Update state on each accepted word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_at_start  <= 1'b1;
            r_blank_run <= 2'd0;
            r_count     <= CW'(1);
        end else if (i_accept) begin
            r_at_start  <= n_at_start;
            r_blank_run <= n_blank_run;
            r_count     <= n_count;
        end
    end

endmodule

// ===== design/tlnef_queue.sv =====
// ----------------------------------------------------------------------------
// tlnef_queue: two-entry queue between front and back
// Holds classified words so that input and output stall independently.
// ----------------------------------------------------------------------------
module tlnef_queue #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wr, r_rd;
    logic [1:0]       r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_mem[r_rd];

    // Store pushed words
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (i_pop) begin
                r_rd <= ~r_rd;
            end
            r_count <= r_count + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

endmodule

// ===== design/tlnef_back.sv =====
// ----------------------------------------------------------------------------
// tlnef_back: output sequencer
// Steps through the number, tab and character bytes of the head word, one
// byte a cycle while the output is not stalled, into a registered output stage.
// ----------------------------------------------------------------------------
module tlnef_back #(
    parameter int NUMBER_DIGITS = 6
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_head_valid,
    input  tlnef_pkg::t_chr            i_head_chr,
    input  logic [NUMBER_DIGITS*8-1:0] i_head_num,
    output logic                       o_pop,
    output logic                       o_tvalid,
    input  logic                       i_tready,
    output logic [7:0]                 o_tdata,
    output logic                       o_tlast
);

    localparam int PW = $clog2(NUMBER_DIGITS + 5);

    logic          r_active;
    logic [PW-1:0] r_pos;
    logic          r_ovalid;
    logic [7:0]    r_odata;
    logic          r_olast;

    logic [PW-1:0] pos;
    logic [7:0]    sel;
    logic          last;
    logic          adv;

    // Pick the byte at the current position
    always_comb begin
        if (r_active) begin
            pos = r_pos;
        end else begin
            pos = i_head_chr.num_en ? '0 : PW'(NUMBER_DIGITS + 1);
        end
        sel = tlnef_pkg::CH_TAB;
        for (int i = 0; i < NUMBER_DIGITS; i++) begin
            if (pos == PW'(i)) begin
                sel = i_head_num[i*8 +: 8];
            end
        end
        for (int k = 0; k < tlnef_pkg::CHR_MAX; k++) begin
            if (pos == PW'(NUMBER_DIGITS + 1 + k)) begin
                sel = i_head_chr.bytes[k];
            end
        end
        last = (pos == PW'(NUMBER_DIGITS + 1) + PW'(i_head_chr.last_idx));
        adv  = i_head_valid && (!r_ovalid || i_tready);
    end

    assign o_pop    = adv && last;
    assign o_tvalid = r_ovalid;
    assign o_tdata  = r_odata;
    assign o_tlast  = r_olast;

    // Advance position and output stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_pos    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (adv) begin
                r_active <= !last;
                r_pos    <= pos + PW'(1);
                r_ovalid <= 1'b1;
            end else if (i_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Load output word
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_odata <= sel;
            r_olast <= last;
        end
    end

endmodule

// ===== design/text_line_number_escape_filter.sv =====
// An accepted input word passes through the queue and the registered output stage.
// Throughput: one output word per cycle while the output is ready; an input word
// yields 1 to NUMBER_DIGITS+5 output words, sent one at a time by the one-byte output stage.
// A squeezed blank line yields no output.
// Reset (synchronous, active low) clears all options, the queue, the line
// start and blank run state, and sets the line count to 1.
// ----------------------------------------------------------------------------
// text_line_number_escape_filter: top level
// Numbers lines, squeezes blank lines and escapes control bytes of a text
// byte stream. Front classifies, a two-entry queue decouples, back emits.
// ----------------------------------------------------------------------------
module text_line_number_escape_filter #(
    parameter int NUMBER_DIGITS = 6
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] in_byte
    input  logic       i_s_tuser,   // [0] new_file
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,   // [7:0] out_byte
    output logic       o_m_tlast,
    input  logic       i_cfg_we,
    input  logic [2:0] i_cfg_idx,
    input  logic [0:0] i_cfg_data
);

    localparam int QW = $bits(tlnef_pkg::t_chr) + NUMBER_DIGITS * 8;

    tlnef_pkg::t_cfg            r_cfg;
    tlnef_pkg::t_chr            f_chr, q_chr;
    logic [NUMBER_DIGITS*8-1:0] f_num, q_num;
    logic                       accept, push, pop, q_full, q_valid;
    logic [QW-1:0]              q_data;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                tlnef_pkg::CFG_NUMBER_NONBLANK:  r_cfg.number_nonblank  <= i_cfg_data[0];
                tlnef_pkg::CFG_NUMBER_ALL:       r_cfg.number_all       <= i_cfg_data[0];
                tlnef_pkg::CFG_SQUEEZE_BLANK:    r_cfg.squeeze_blank    <= i_cfg_data[0];
                tlnef_pkg::CFG_MARK_LINE_END:    r_cfg.mark_line_end    <= i_cfg_data[0];
                tlnef_pkg::CFG_SHOW_TABS:        r_cfg.show_tabs        <= i_cfg_data[0];
                tlnef_pkg::CFG_SHOW_NONPRINTING: r_cfg.show_nonprinting <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    assign o_s_tready = !q_full;
    assign accept     = i_s_tvalid && !q_full;

    tlnef_front #(.NUMBER_DIGITS(NUMBER_DIGITS)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_accept   (accept),
        .i_byte     (i_s_tdata),
        .i_new_file (i_s_tuser),
        .o_push     (push),
        .o_chr      (f_chr),
        .o_num      (f_num)
    );

    tlnef_queue #(.WIDTH(QW)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({f_num, f_chr}),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    assign {q_num, q_chr} = q_data;

    tlnef_back #(.NUMBER_DIGITS(NUMBER_DIGITS)) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (q_valid),
        .i_head_chr   (q_chr),
        .i_head_num   (q_num),
        .o_pop        (pop),
        .o_tvalid     (o_m_tvalid),
        .i_tready     (i_m_tready),
        .o_tdata      (o_m_tdata),
        .o_tlast      (o_m_tlast)
    );

endmodule

// ===== design/tlnef_checker.sv =====
// ----------------------------------------------------------------------------
// tlnef_checker: port-level checks of the filter
// Watches the stream ports for reset behavior, held output words, run length
// and input readiness while the output stage is empty.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tlnef_checker #(
    parameter int NUMBER_DIGITS = 6
) (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_s_tready,
    input logic       o_m_tvalid,
    input logic       i_m_tready,
    input logic [7:0] o_m_tdata,
    input logic       o_m_tlast
);

    localparam int RW = $clog2(NUMBER_DIGITS + 5);

    logic [RW-1:0] r_run;

    // Count words of the current run
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= '0;
        end else if (o_m_tvalid && i_m_tready) begin
            r_run <= o_m_tlast ? '0 : r_run + RW'(1);
        end
    end

    `ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> !o_m_tvalid, "output valid after reset")
    `ASSERT_CLK(a_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast), "stalled output word changed")
    `ASSERT_CLK(a_run_len, i_clk, i_rst_n, o_m_tvalid |-> r_run <= RW'(NUMBER_DIGITS + 4), "run longer than number, tab and escape")
    `ASSERT_CLK(a_ready_when_empty, i_clk, i_rst_n, !o_m_tvalid |-> o_s_tready, "input blocked while output stage empty")

endmodule

bind text_line_number_escape_filter tlnef_checker #(.NUMBER_DIGITS(NUMBER_DIGITS)) u_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast)
);
